[rtl/core/tcc_pkg.sv]
// Package for the text console cell engine.
// Holds the command and register codes, field widths and default sizes.
// No dependencies.
`default_nettype none

package tcc_pkg;

  localparam int unsigned COLS_DEFAULT = 32;
  localparam int unsigned ROWS_DEFAULT = 24;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned CURSOR_W   = 5;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned TAB_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [TAB_W-1:0] TAB_WIDTH_RESET = 6'd4;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_TAB     = 3'd1,
    OP_NEWLINE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_LOCATE  = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAB_WIDTH = 2'd0,
    CFG_INK       = 2'd1,
    CFG_PAPER     = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

[rtl/core/tcc_cmd_if.sv]
// Valid/ready channels of the text console cell engine: command, result and
// register write. Depends on tcc_pkg for the field widths.
`default_nettype none

interface tcc_cmd_if
  import tcc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [CHAR_W-1:0]    char_code;
  logic                 last_in_string;
  logic [COORD_W-1:0]   column;
  logic [COORD_W-1:0]   row;

  modport source (output valid, op, char_code, last_in_string, column, row, input ready);
  modport sink   (input valid, op, char_code, last_in_string, column, row, output ready);
endinterface

interface tcc_res_if
  import tcc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    cell_char;
  logic                 out_of_range;
  logic [CURSOR_W-1:0]  cursor_column;
  logic [CURSOR_W-1:0]  cursor_row;
  logic                 scrolled;

  modport source (output valid, cell_char, out_of_range, cursor_column, cursor_row, scrolled,
                  input ready);
  modport sink   (input valid, cell_char, out_of_range, cursor_column, cursor_row, scrolled,
                  output ready);
endinterface

interface tcc_cfg_if
  import tcc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   reg_index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

[rtl/core/text_console_cell_engine.sv]
// Text console cell engine: a COLS x ROWS screen of character and color
// cells with a cursor, one command per request. Depends on tcc_pkg,
// the channel interfaces and tcc_ram.
//
// The steps of each command follow from the single write port of the cell
// memories: a character write, a locate, a new line or an unused code is done
// on acceptance unless it scrolls; a read waits in ST_RD for the registered
// memory read, unless its coordinates fall off the screen. A scroll sweeps the
// screen one cell a cycle, then blanks the characters of the bottom row. A clear
// writes every cell in turn. A tab first reduces the start column modulo the tab
// width by repeated subtraction, then blanks cells one at a time, and scrolls if
// it wraps off the bottom row. After reset the block runs a clearing pass before
// it takes its first command; register writes are taken at any time.
`default_nettype none

module text_console_cell_engine
  import tcc_pkg::*;
#(
  parameter int unsigned COLS = COLS_DEFAULT,
  parameter int unsigned ROWS = ROWS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcc_cmd_if.sink    in_cmd,
  tcc_res_if.source  out_res,
  tcc_cfg_if.sink    cfg_wr
);

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned XW    = $clog2(COLS);
  localparam int unsigned YW    = $clog2(ROWS);
  localparam int unsigned REM_W = TAB_W + 1;
  localparam int unsigned CLR_W = 2 * COLOR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_TAB_MOD,
    ST_TAB_RUN,
    ST_SCR_MOVE,
    ST_SCR_BOT,
    ST_CLR
  } state_t;

  state_t               state_r, state_nxt;
  logic [XW-1:0]        cur_x_r, cur_x_nxt;
  logic [YW-1:0]        cur_y_r, cur_y_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [CLR_W-1:0]     fill_r, fill_nxt;
  logic                 init_r, init_nxt;
  logic [TAB_W-1:0]     tab_width_r;
  logic [COLOR_W-1:0]   ink_r;
  logic [COLOR_W-1:0]   paper_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_oor_r, out_oor_nxt;
  logic [CURSOR_W-1:0]  out_col_r, out_col_nxt;
  logic [CURSOR_W-1:0]  out_row_r, out_row_nxt;
  logic                 out_scr_r, out_scr_nxt;

  // Memory ports
  logic                 ch_we, co_we;
  logic [AW-1:0]        waddr, raddr;
  logic [CHAR_W-1:0]    ch_wdata, ch_rdata;
  logic [CLR_W-1:0]     co_wdata, co_rdata;

  logic                 out_free;
  logic                 in_fire;
  logic                 at_last_col, at_last_row;
  logic [XW-1:0]        step_x;
  logic [YW-1:0]        step_y;
  logic [AW-1:0]        cur_addr, rd_addr;
  logic                 rd_oor;
  logic [REM_W-1:0]     tab_w;
  logic [REM_W-1:0]     rem_inc;
  logic [XW-1:0]        loc_x;
  logic [YW-1:0]        loc_y;
  logic                 ld;
  logic [CHAR_W-1:0]    ld_char;
  logic                 ld_oor;
  logic                 ld_scr;

  tcc_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (waddr),
    .wdata (ch_wdata),
    .raddr (raddr),
    .rdata (ch_rdata)
  );

  // Ink in the upper nibble, paper in the lower.
  tcc_ram #(.WIDTH(CLR_W), .DEPTH(CELLS)) u_color_ram (
    .clk   (clk),
    .we    (co_we),
    .waddr (waddr),
    .wdata (co_wdata),
    .raddr (raddr),
    .rdata (co_rdata)
  );

  assign out_free      = !out_valid_r || out_res.ready;
  assign in_cmd.ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire       = in_cmd.valid && in_cmd.ready;
  assign cfg_wr.ready  = 1'b1;

  assign out_res.valid         = out_valid_r;
  assign out_res.cell_char     = out_char_r;
  assign out_res.out_of_range  = out_oor_r;
  assign out_res.cursor_column = out_col_r;
  assign out_res.cursor_row    = out_row_r;
  assign out_res.scrolled      = out_scr_r;

  assign at_last_col = (cur_x_r == XW'(COLS - 1));
  assign at_last_row = (cur_y_r == YW'(ROWS - 1));
  assign step_x      = at_last_col ? '0 : cur_x_r + XW'(1);
  // On a wrap at the bottom row the scroll leaves the cursor on the last row.
  assign step_y      = (at_last_col && !at_last_row) ? cur_y_r + YW'(1) : cur_y_r;

  assign cur_addr = AW'(cur_y_r * COLS + cur_x_r);
  assign rd_addr  = AW'(in_cmd.row * COLS + in_cmd.column);
  assign rd_oor   = ({1'b0, in_cmd.column} >= (COORD_W + 1)'(COLS)) ||
                    ({1'b0, in_cmd.row} >= (COORD_W + 1)'(ROWS));
  assign loc_x    = ({1'b0, in_cmd.column} < (COORD_W + 1)'(COLS)) ?
                    XW'(in_cmd.column) : XW'(COLS - 1);
  assign loc_y    = ({1'b0, in_cmd.row} < (COORD_W + 1)'(ROWS)) ?
                    YW'(in_cmd.row) : YW'(ROWS - 1);

  // A tab width of zero runs to the end of the line.
  assign tab_w   = (tab_width_r == '0) ? REM_W'(64) : {1'b0, tab_width_r};
  assign rem_inc = rem_r + REM_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    ptr_nxt       = ptr_r;
    rem_nxt       = rem_r;
    fill_nxt      = fill_r;
    init_nxt      = init_r;
    ch_we         = 1'b0;
    co_we         = 1'b0;
    waddr         = cur_addr;
    raddr         = rd_addr;
    ch_wdata      = '0;
    co_wdata      = {ink_r, paper_r};
    ld            = 1'b0;
    ld_char       = '0;
    ld_oor        = 1'b0;
    ld_scr        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd.op)
            OP_WRITE: begin
              ch_we    = 1'b1;
              co_we    = 1'b1;
              ch_wdata = in_cmd.char_code;
              if (in_cmd.last_in_string && at_last_col && at_last_row) begin
                ld = 1'b1;
              end else begin
                cur_x_nxt = step_x;
                cur_y_nxt = step_y;
                if (at_last_col && at_last_row) begin
                  ptr_nxt   = '0;
                  state_nxt = ST_SCR_MOVE;
                end else begin
                  ld = 1'b1;
                end
              end
            end
            OP_TAB: begin
              rem_nxt   = REM_W'(cur_x_r);
              state_nxt = ST_TAB_MOD;
            end
            OP_NEWLINE: begin
              cur_x_nxt = '0;
              if (at_last_row) begin
                ptr_nxt   = '0;
                state_nxt = ST_SCR_MOVE;
              end else begin
                cur_y_nxt = cur_y_r + YW'(1);
                ld        = 1'b1;
              end
            end
            OP_CLEAR: begin
              cur_x_nxt = '0;
              cur_y_nxt = '0;
              fill_nxt  = {ink_r, paper_r};
              init_nxt  = 1'b0;
              ptr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            OP_LOCATE: begin
              cur_x_nxt = loc_x;
              cur_y_nxt = loc_y;
              ld        = 1'b1;
            end
            OP_READ: begin
              if (rd_oor) begin
                ld_oor = 1'b1;
                ld     = 1'b1;
              end else begin
                state_nxt = ST_RD;
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        ld_char   = ch_rdata;
        ld        = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_TAB_MOD: begin
        // Reduce the start column modulo the tab width, one subtraction a cycle.
        if (rem_r >= tab_w) begin
          rem_nxt = rem_r - tab_w;
        end else begin
          state_nxt = ST_TAB_RUN;
        end
      end
      ST_TAB_RUN: begin
        ch_we     = 1'b1;
        co_we     = 1'b1;
        cur_x_nxt = step_x;
        cur_y_nxt = step_y;
        rem_nxt   = rem_inc;
        if (at_last_col && at_last_row) begin
          ptr_nxt   = '0;
          state_nxt = ST_SCR_MOVE;
        end else if (at_last_col || (rem_inc == tab_w)) begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCR_MOVE: begin
        // Read a cell one row down; write it one row up in the next cycle, when the registered read data arrives.
        raddr    = ptr_r + AW'(COLS);
        waddr    = ptr_r - AW'(1);
        ch_wdata = ch_rdata;
        co_wdata = co_rdata;
        ch_we    = (ptr_r != '0);
        co_we    = (ptr_r != '0);
        if (ptr_r == AW'(CELLS - COLS)) begin
          state_nxt = ST_SCR_BOT;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_SCR_BOT: begin
        // The bottom row loses its characters and keeps its colors.
        waddr = ptr_r;
        ch_we = 1'b1;
        if (ptr_r == AW'(CELLS - 1)) begin
          ld_scr    = 1'b1;
          ld        = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_CLR: begin
        waddr    = ptr_r;
        co_wdata = fill_r;
        ch_we    = 1'b1;
        co_we    = 1'b1;
        if (ptr_r == AW'(CELLS - 1)) begin
          ld        = !init_r;
          init_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_res.ready;
    out_char_nxt  = out_char_r;
    out_oor_nxt   = out_oor_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_scr_nxt   = out_scr_r;
    if (ld) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ld_char;
      out_oor_nxt   = ld_oor;
      out_col_nxt   = CURSOR_W'(cur_x_nxt);
      out_row_nxt   = CURSOR_W'(cur_y_nxt);
      out_scr_nxt   = ld_scr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      ptr_r       <= '0;
      fill_r      <= '0;
      init_r      <= 1'b1;
      tab_width_r <= TAB_WIDTH_RESET;
      ink_r       <= '0;
      paper_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.reg_index)
          CFG_TAB_WIDTH: tab_width_r <= cfg_wr.wdata;
          CFG_INK:       ink_r       <= cfg_wr.wdata[COLOR_W-1:0];
          CFG_PAPER:     paper_r     <= cfg_wr.wdata[COLOR_W-1:0];
          default:       ;
        endcase
      end
    end
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_oor_r  <= out_oor_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  // A request is never taken while an undelivered result would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_cmd.valid && in_cmd.ready) |-> (!out_valid_r || out_res.ready))
    else $error("request accepted while result slot busy");

  // The cursor always stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_x_r <= XW'(COLS - 1)) && (cur_y_r <= YW'(ROWS - 1)))
    else $error("cursor off screen");

  // During a scroll sweep the cursor already sits at the start of the last row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCR_MOVE || state_r == ST_SCR_BOT) |->
      (cur_x_r == '0) && (cur_y_r == YW'(ROWS - 1)))
    else $error("cursor not at last row during scroll");

  // A scroll result is only produced at the end of the bottom-row pass.
  a_scroll_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_scr_r) |-> ($past(state_r) == ST_SCR_BOT))
    else $error("scroll flag without a scroll");

endmodule

`default_nettype wire

[rtl/core/tcc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
